### rtl/wsc_pkg.sv
// Shared types and constants for the wiper sweep controller.
`default_nettype none
package wsc_pkg;

	// Full-scale reading of the selector pots.
	localparam int unsigned POT_FULL = 4095;

	// Depth of the queue between the classifier and the sweep engine.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_PEAK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_HIGH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SHORT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MEDIUM = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LONG   = 3'd7;
	localparam int unsigned CFG_DATA_W = 20;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_INT = 2'd1,
		MODE_LO  = 2'd2,
		MODE_HI  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_REST = 2'd0,
		PH_RISE = 2'd1,
		PH_FALL = 2'd2
	} phase_t;

	// Interval choices.
	localparam logic [1:0] SEL_LONG   = 2'd0;
	localparam logic [1:0] SEL_MEDIUM = 2'd1;

	typedef struct packed {
		logic [4:0]  tick_ms;
		logic [19:0] duty_floor;
		logic [19:0] duty_peak;
		logic [15:0] step_low;
		logic [15:0] step_high;
		logic [13:0] delay_short;
		logic [13:0] delay_medium;
		logic [13:0] delay_long;
	} cfg_t;

	typedef struct packed {
		logic        ignition_on;
		logic [11:0] mode_pot;
		logic [11:0] interval_pot;
	} in_item_t;

	typedef struct packed {
		logic signed [21:0] duty_out;
		logic               duty_update;
		logic [1:0]         wiper_mode;
		logic [1:0]         interval_choice;
		logic [1:0]         sweep_phase;
	} out_item_t;

	// Classified tick handed from the front end to the sweep engine.
	typedef struct packed {
		logic       upd;
		mode_t      mode;
		logic [1:0] choice;
	} tick_cls_t;

endpackage
`default_nettype wire

### rtl/wiper_sweep_controller.sv
// Wiper sweep controller top level: configuration registers, front end, queue, sweep engine.
//
// Each input transfer on in_valid/in_ready is one system tick carrying the
// ignition flag and the mode and interval pot readings. Each tick yields
// exactly one result transfer on out_valid/out_ready with the servo duty as
// it stood before the tick, the sweep period flag, and the mode, interval
// choice and sweep phase after the tick.
// Each tick is written into the queue and its result into the result
// register. One tick is taken every cycle while the queue is not full;
// the front end decodes mode and period timing, and the sweep engine works
// out the duty for each tick it pops.
// A two-entry queue separates the two halves. When the receiver stalls, the
// result register holds and the queue fills; in_ready drops once it is full
// and rises again in the cycle after a result is taken.
// Configuration writes on cfg_valid/cfg_ready (always ready) update one register
// per transfer; the user must make them while no tick is in flight (not enforced).
// Reset restores the default configuration, mode OFF, phase falling, duty 0,
// and empties the queue and the result register.
`default_nettype none
module wiper_sweep_controller import wsc_pkg::*; #(
	parameter int unsigned SWEEP_PERIOD_MS  = 20,
	parameter int unsigned INTERVAL_CHOICES = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      q_not_full, q_not_empty, push, pop;
	tick_cls_t push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms      <= 5'd1;
			cfg_q.duty_floor   <= 20'd25000;
			cfg_q.duty_peak    <= 20'd58000;
			cfg_q.step_low     <= 16'd1773;
			cfg_q.step_high    <= 16'd2364;
			cfg_q.delay_short  <= 14'd3000;
			cfg_q.delay_medium <= 14'd6000;
			cfg_q.delay_long   <= 14'd8000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TICK_MS:      cfg_q.tick_ms      <= cfg_data[4:0];
				CFG_DUTY_FLOOR:   cfg_q.duty_floor   <= cfg_data[19:0];
				CFG_DUTY_PEAK:    cfg_q.duty_peak    <= cfg_data[19:0];
				CFG_STEP_LOW:     cfg_q.step_low     <= cfg_data[15:0];
				CFG_STEP_HIGH:    cfg_q.step_high    <= cfg_data[15:0];
				CFG_DELAY_SHORT:  cfg_q.delay_short  <= cfg_data[13:0];
				CFG_DELAY_MEDIUM: cfg_q.delay_medium <= cfg_data[13:0];
				CFG_DELAY_LONG:   cfg_q.delay_long   <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	wsc_front #(
		.SWEEP_PERIOD_MS (SWEEP_PERIOD_MS),
		.INTERVAL_CHOICES(INTERVAL_CHOICES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_ms (cfg_q.tick_ms),
		.in_valid(in_valid),
		.in_data (in_data),
		.in_ready(in_ready),
		.q_ready (q_not_full),
		.push    (push),
		.entry   (push_data)
	);

	wsc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.not_full (q_not_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.pop_data (pop_data)
	);

	wsc_back #(
		.SWEEP_PERIOD_MS(SWEEP_PERIOD_MS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_not_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

### rtl/wsc_front.sv
// Front end: mode selection, sweep period timing and interval pot decoding.
`default_nettype none
module wsc_front import wsc_pkg::*; #(
	parameter int unsigned SWEEP_PERIOD_MS  = 20,
	parameter int unsigned INTERVAL_CHOICES = 3
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic [4:0] tick_ms,
	input  wire logic      in_valid,
	input  wire in_item_t  in_data,
	output logic           in_ready,
	input  wire logic      q_ready,
	output logic           push,
	output tick_cls_t      entry
);

	localparam int unsigned PACC_W = $clog2(SWEEP_PERIOD_MS + 1);
	localparam int unsigned PSUM_W = $clog2(SWEEP_PERIOD_MS + 32);
	localparam logic [18:0] HI_LIM    = 19'(80 * POT_FULL);
	localparam logic [18:0] LO_MIN    = 19'(55 * POT_FULL);
	localparam logic [18:0] LO_MAX    = 19'(70 * POT_FULL);
	localparam logic [18:0] INT_MIN   = 19'(30 * POT_FULL);
	localparam logic [18:0] INT_MAX   = 19'(45 * POT_FULL);
	localparam logic [18:0] OFF_LIM   = 19'(20 * POT_FULL);

	mode_t             mode_q, mode_nx;
	logic [PACC_W-1:0] period_q, period_nx;
	logic [PSUM_W-1:0] psum;
	logic [18:0]       pct;
	logic [13:0]       q_scaled;
	logic              upd;
	logic [1:0]        choice;

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;

	always_comb begin
		pct = 19'(in_data.mode_pot) * 19'd100;
		mode_nx = mode_q;
		if (!in_data.ignition_on) begin
			mode_nx = MODE_OFF;
		end else if (pct > HI_LIM) begin
			mode_nx = MODE_HI;
		end else if (pct > LO_MIN && pct < LO_MAX) begin
			mode_nx = MODE_LO;
		end else if (pct > INT_MIN && pct < INT_MAX) begin
			mode_nx = MODE_INT;
		end else if (pct < OFF_LIM) begin
			mode_nx = MODE_OFF;
		end

		psum = PSUM_W'(period_q) + PSUM_W'(tick_ms);
		upd = psum >= PSUM_W'(SWEEP_PERIOD_MS);
		period_nx = upd ? '0 : PACC_W'(psum);

		// The lowest zone that the reading falls below wins.
		q_scaled = 14'(in_data.interval_pot) * 14'(INTERVAL_CHOICES);
		choice = 2'(INTERVAL_CHOICES - 1);
		for (int i = INTERVAL_CHOICES - 2; i >= 0; i--) begin
			if (q_scaled < 14'((i + 1) * POT_FULL)) begin
				choice = 2'(i);
			end
		end
	end

	assign entry = '{upd: upd, mode: mode_nx, choice: choice};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			period_q <= '0;
		end else if (push) begin
			mode_q   <= mode_nx;
			period_q <= period_nx;
		end
	end

endmodule
`default_nettype wire

### rtl/wsc_queue.sv
// Small register queue between the front end and the sweep engine.
`default_nettype none
module wsc_queue import wsc_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire tick_cls_t push_data,
	output logic           not_full,
	input  wire logic      pop,
	output logic           not_empty,
	output tick_cls_t      pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tick_cls_t         mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign not_full  = count_q != CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/wsc_back.sv
// Sweep engine: servo duty, sweep phase, interval timer and result register.
`default_nettype none
module wsc_back import wsc_pkg::*; #(
	parameter int unsigned SWEEP_PERIOD_MS = 20
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      q_valid,
	input  wire tick_cls_t q_data,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	phase_t             phase_q, phase_nx;
	logic signed [21:0] duty_q, duty_nx;
	logic [13:0]        iacc_q, iacc_nx;
	logic [1:0]         dsel_q, dsel_nx;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic [15:0]        step_sel;
	logic signed [22:0] duty_w, up_w, dn_w, floor_s, peak_s;
	logic signed [21:0] duty_up, duty_dn;
	logic [14:0]        isum;
	logic [13:0]        delay_sel;
	logic               do_retract;

	// Clamp a 23-bit result into the 22-bit signed duty range.
	function automatic logic signed [21:0] sat22(input logic signed [22:0] v);
		logic signed [21:0] r;
		if (v[22] != v[21]) begin
			r = v[22] ? {1'b1, 21'd0} : {1'b0, {21{1'b1}}};
		end else begin
			r = v[21:0];
		end
		return r;
	endfunction

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		step_sel = (q_data.mode == MODE_HI) ? cfg.step_high : cfg.step_low;
		duty_w   = {duty_q[21], duty_q};
		floor_s  = signed'({3'b000, cfg.duty_floor});
		peak_s   = signed'({3'b000, cfg.duty_peak});
		up_w     = duty_w + signed'({7'd0, step_sel});
		dn_w     = duty_w - signed'({7'd0, step_sel});
		duty_up  = sat22(up_w);
		duty_dn  = sat22(dn_w);

		case (q_data.choice)
			SEL_LONG:   delay_sel = cfg.delay_long;
			SEL_MEDIUM: delay_sel = cfg.delay_medium;
			default:    delay_sel = cfg.delay_short;
		endcase
		isum = 15'(iacc_q) + 15'(SWEEP_PERIOD_MS);

		// OFF always retracts; INT retracts while resting out its delay.
		do_retract = (q_data.mode == MODE_OFF) ||
			(q_data.mode == MODE_INT && iacc_q != '0 && phase_q == PH_REST);

		phase_nx = phase_q;
		duty_nx  = duty_q;
		iacc_nx  = iacc_q;
		dsel_nx  = dsel_q;
		if (q_data.upd) begin
			if (do_retract) begin
				if (duty_w > floor_s) begin
					duty_nx = duty_dn;
				end else begin
					phase_nx = PH_REST;
				end
			end else begin
				unique case (phase_q)
					PH_REST: begin
						phase_nx = PH_RISE;
					end
					PH_RISE: begin
						duty_nx = duty_up;
						if (signed'({duty_up[21], duty_up}) >= peak_s) begin
							phase_nx = PH_FALL;
						end
					end
					default: begin
						duty_nx = duty_dn;
						if (signed'({duty_dn[21], duty_dn}) <= floor_s) begin
							phase_nx = PH_REST;
						end
					end
				endcase
			end
			if (q_data.mode == MODE_INT) begin
				dsel_nx = q_data.choice;
				iacc_nx = (isum > 15'(delay_sel)) ? '0 : iacc_nx + 14'(SWEEP_PERIOD_MS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FALL;
			duty_q      <= '0;
			iacc_q      <= '0;
			dsel_q      <= SEL_LONG;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_nx;
				duty_q      <= duty_nx;
				iacc_q      <= iacc_nx;
				dsel_q      <= dsel_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q.duty_out        <= duty_q;
			out_data_q.duty_update     <= q_data.upd;
			out_data_q.wiper_mode      <= q_data.mode;
			out_data_q.interval_choice <= dsel_nx;
			out_data_q.sweep_phase     <= phase_nx;
		end
	end

endmodule
`default_nettype wire

### rtl/wsc_checker.sv
// Port-level checker for the wiper sweep controller and its bind.
`default_nettype none
module wsc_checker import wsc_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	out_item_t last_q;
	logic      last_valid_q;
	logic      out_xfer;

	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
		end else if (out_xfer) begin
			last_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			last_q <= out_data;
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Without a sweep period the duty cannot move.
	a_duty_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last_valid_q && !last_q.duty_update |->
			out_data.duty_out == last_q.duty_out)
		else $error("duty moved without a sweep period");

	// The phase only changes on a sweep period.
	a_phase_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last_valid_q && !out_data.duty_update |->
			out_data.sweep_phase == last_q.sweep_phase)
		else $error("phase changed without a sweep period");

	// The interval choice is only sampled on sweep periods spent in INT mode.
	a_choice_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last_valid_q &&
			(!out_data.duty_update || out_data.wiper_mode != MODE_INT) |->
			out_data.interval_choice == last_q.interval_choice)
		else $error("interval choice changed outside an INT period");

endmodule

bind wiper_sweep_controller wsc_checker u_wsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
`default_nettype wire

### verif/wiper_sweep_checker.sv
// Checker for the wiper sweep controller: predicts each tick's result and compares transfers.
module wiper_sweep_checker import wsc_pkg::*; #(
	parameter int unsigned SWEEP_PERIOD_MS  = 20,
	parameter int unsigned INTERVAL_CHOICES = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DUTY_TOP    = 2097151;
	localparam int DUTY_BOTTOM = -2097152;

	cfg_t        regs;
	mode_t       mode;
	phase_t      phase;
	int          duty;
	int unsigned period_acc;
	int unsigned interval_acc;
	logic [1:0]  delay_sel;
	out_item_t   expected_ticks [$];
	out_item_t   predicted;
	int          fail_count = 0;
	int          result_count = 0;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string msg);
		// Keep the log short on a badly broken block; every mismatch still counts.
		if (fail_count < 50)
			$display("MISMATCH result %0d: %s", result_count, msg);
		fail_count++;
	endtask

	function automatic int clamp_duty(input int v);
		if (v > DUTY_TOP)
			return DUTY_TOP;
		if (v < DUTY_BOTTOM)
			return DUTY_BOTTOM;
		return v;
	endfunction

	task automatic sweep_advance(input int step);
		case (phase)
			PH_REST: begin
				phase = PH_RISE;
			end
			PH_RISE: begin
				duty = clamp_duty(duty + step);
				if (duty >= int'(regs.duty_peak))
					phase = PH_FALL;
			end
			default: begin
				duty = clamp_duty(duty - step);
				if (duty <= int'(regs.duty_floor))
					phase = PH_REST;
			end
		endcase
	endtask

	task automatic retract_duty();
		if (duty > int'(regs.duty_floor))
			duty = clamp_duty(duty - int'(regs.step_low));
		else
			phase = PH_REST;
	endtask

	task automatic predict_tick(input in_item_t it, output out_item_t res);
		int unsigned x;
		int unsigned lim;
		int          shown;
		int          choice;
		logic        upd;
		shown = duty;
		upd = 1'b0;
		x = 100 * it.mode_pot;
		if (!it.ignition_on)
			mode = MODE_OFF;
		else if (x > 80 * POT_FULL)
			mode = MODE_HI;
		else if (x > 55 * POT_FULL && x < 70 * POT_FULL)
			mode = MODE_LO;
		else if (x > 30 * POT_FULL && x < 45 * POT_FULL)
			mode = MODE_INT;
		else if (x < 20 * POT_FULL)
			mode = MODE_OFF;

		period_acc = period_acc + regs.tick_ms;
		if (period_acc >= SWEEP_PERIOD_MS) begin
			period_acc = 0;
			upd = 1'b1;
			case (mode)
				MODE_LO: sweep_advance(regs.step_low);
				MODE_HI: sweep_advance(regs.step_high);
				MODE_INT: begin
					// Lowest zone whose upper edge lies above the reading wins.
					choice = INTERVAL_CHOICES - 1;
					for (int i = INTERVAL_CHOICES - 2; i >= 0; i--) begin
						if (it.interval_pot * INTERVAL_CHOICES < (i + 1) * POT_FULL)
							choice = i;
					end
					delay_sel = choice[1:0];
					if (interval_acc != 0 && phase == PH_REST)
						retract_duty();
					else
						sweep_advance(regs.step_low);
					interval_acc = interval_acc + SWEEP_PERIOD_MS;
					case (delay_sel)
						SEL_LONG:   lim = regs.delay_long;
						SEL_MEDIUM: lim = regs.delay_medium;
						default:    lim = regs.delay_short;
					endcase
					if (interval_acc > lim)
						interval_acc = 0;
				end
				default: retract_duty();
			endcase
		end

		res.duty_out        = shown[21:0];
		res.duty_update     = upd;
		res.wiper_mode      = mode;
		res.interval_choice = delay_sel;
		res.sweep_phase     = phase;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_ticks.size() == 0) begin
			report_mismatch("result transfer with no tick outstanding");
		end else begin
			want = expected_ticks.pop_front();
			if (got.duty_out !== want.duty_out)
				report_mismatch($sformatf("duty_out %0d, expected %0d",
					got.duty_out, want.duty_out));
			if (got.duty_update !== want.duty_update)
				report_mismatch($sformatf("duty_update %0b, expected %0b",
					got.duty_update, want.duty_update));
			if (got.wiper_mode !== want.wiper_mode)
				report_mismatch($sformatf("wiper_mode %0d, expected %0d",
					got.wiper_mode, want.wiper_mode));
			if (got.interval_choice !== want.interval_choice)
				report_mismatch($sformatf("interval_choice %0d, expected %0d",
					got.interval_choice, want.interval_choice));
			if (got.sweep_phase !== want.sweep_phase)
				report_mismatch($sformatf("sweep_phase %0d, expected %0d",
					got.sweep_phase, want.sweep_phase));
		end
		result_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{tick_ms: 5'd1, duty_floor: 20'd25000, duty_peak: 20'd58000,
				step_low: 16'd1773, step_high: 16'd2364, delay_short: 14'd3000,
				delay_medium: 14'd6000, delay_long: 14'd8000};
			mode = MODE_OFF;
			phase = PH_FALL;
			duty = 0;
			period_acc = 0;
			interval_acc = 0;
			delay_sel = SEL_LONG;
			expected_ticks.delete();
			results_due <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TICK_MS:      regs.tick_ms      = cfg_data[4:0];
					CFG_DUTY_FLOOR:   regs.duty_floor   = cfg_data[19:0];
					CFG_DUTY_PEAK:    regs.duty_peak    = cfg_data[19:0];
					CFG_STEP_LOW:     regs.step_low     = cfg_data[15:0];
					CFG_STEP_HIGH:    regs.step_high    = cfg_data[15:0];
					CFG_DELAY_SHORT:  regs.delay_short  = cfg_data[13:0];
					CFG_DELAY_MEDIUM: regs.delay_medium = cfg_data[13:0];
					CFG_DELAY_LONG:   regs.delay_long   = cfg_data[13:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_tick(in_data, predicted);
				expected_ticks.push_back(predicted);
			end
			results_due <= expected_ticks.size();
		end
	end

endmodule

### verif/tb_wiper_sweep_controller.sv
// Testbench top for the wiper sweep controller: clock, reset, stimulus, stalls and verdict.
module tb_wiper_sweep_controller import wsc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int TICKS_PER_PHASE = 113;
	localparam int DRAIN_SLACK     = 8;

	// Register settings used by the phases of the run.
	localparam int SET_DIRECTED   = 0;
	localparam int SET_TYPICAL    = 1;
	localparam int SET_WIDEST     = 2;
	localparam int SET_NARROWEST  = 3;
	localparam int SET_ZERO_TICK  = 4;
	localparam int SET_MISORDERED = 5;
	localparam int SET_RAW        = 6;

	localparam int PHASE_PLAN [10] = '{SET_TYPICAL, SET_WIDEST, SET_NARROWEST, SET_ZERO_TICK,
		SET_MISORDERED, SET_RAW, SET_TYPICAL, SET_RAW, SET_MISORDERED, SET_TYPICAL};

	// Mode pot zones the random ticks dwell in.
	localparam int ZONE_OFF  = 0;
	localparam int ZONE_INT  = 1;
	localparam int ZONE_LO   = 2;
	localparam int ZONE_HI   = 3;
	localparam int ZONE_DEAD = 4;
	localparam int ZONE_ANY  = 5;

	localparam int ZONE_PICK [10] = '{ZONE_OFF, ZONE_INT, ZONE_INT, ZONE_INT, ZONE_LO,
		ZONE_LO, ZONE_HI, ZONE_HI, ZONE_DEAD, ZONE_ANY};

	localparam int READY_PCT [4] = '{100, 80, 45, 10};

	// Zone edges, ignition, and each interval boundary, with one period per tick.
	localparam in_item_t DIRECTED_TICKS [22] = '{
		{1'b0, 12'd4095, 12'd4095},
		{1'b1, 12'd4095, 12'd0},
		{1'b1, 12'd3277, 12'd4095},
		{1'b1, 12'd3276, 12'd0},
		{1'b1, 12'd2866, 12'd0},
		{1'b1, 12'd2253, 12'd0},
		{1'b1, 12'd2252, 12'd0},
		{1'b1, 12'd1842, 12'd0},
		{1'b1, 12'd1229, 12'd1364},
		{1'b1, 12'd1229, 12'd1365},
		{1'b1, 12'd1500, 12'd2729},
		{1'b1, 12'd1500, 12'd2730},
		{1'b1, 12'd1500, 12'd4095},
		{1'b1, 12'd1228, 12'd0},
		{1'b1, 12'd819,  12'd2000},
		{1'b1, 12'd818,  12'd0},
		{1'b1, 12'd0,    12'd4095},
		{1'b1, 12'd4095, 12'd4095},
		{1'b1, 12'd3000, 12'd0},
		{1'b0, 12'd0,    12'd0},
		{1'b1, 12'd1229, 12'd0},
		{1'b1, 12'd1229, 12'd4095}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    mismatches;
	int                    results_due;
	int                    cycle_count = 0;
	int                    burst_left = 0;
	int                    style_left = 0;
	int                    ready_pct = 100;

	wiper_sweep_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wiper_sweep_checker sweep_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The receiver switches between stall densities at randomly chosen times.
	always @(posedge clk) begin
		if (style_left == 0) begin
			style_left <= $urandom_range(20, 300);
			ready_pct  <= READY_PCT[$urandom_range(0, 3)];
		end else begin
			style_left <= style_left - 1;
		end
		out_ready <= ($urandom_range(0, 99) < ready_pct);
	end

	task automatic send_tick(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds the sender off until every outstanding tick has produced its result.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic configure(input int setting);
		logic [CFG_DATA_W-1:0] v [8];
		v[CFG_TICK_MS]      = $urandom_range(10, 31);
		v[CFG_DUTY_FLOOR]   = $urandom_range(0, 40000);
		v[CFG_DUTY_PEAK]    = v[CFG_DUTY_FLOOR] + $urandom_range(0, 60000);
		v[CFG_STEP_LOW]     = $urandom_range(500, 8000);
		v[CFG_STEP_HIGH]    = $urandom_range(500, 12000);
		v[CFG_DELAY_SHORT]  = $urandom_range(0, 600);
		v[CFG_DELAY_MEDIUM] = $urandom_range(0, 600);
		v[CFG_DELAY_LONG]   = $urandom_range(0, 600);
		case (setting)
			SET_DIRECTED: begin
				v[CFG_TICK_MS]      = 20;
				v[CFG_DUTY_FLOOR]   = 25000;
				v[CFG_DUTY_PEAK]    = 58000;
				v[CFG_STEP_LOW]     = 1773;
				v[CFG_STEP_HIGH]    = 2364;
				v[CFG_DELAY_SHORT]  = 0;
				v[CFG_DELAY_MEDIUM] = 20;
				v[CFG_DELAY_LONG]   = 40;
			end
			SET_WIDEST: begin
				v[CFG_TICK_MS]      = 31;
				v[CFG_DUTY_FLOOR]   = 0;
				v[CFG_DUTY_PEAK]    = 1000000;
				v[CFG_STEP_LOW]     = 65535;
				v[CFG_STEP_HIGH]    = 65535;
				v[CFG_DELAY_SHORT]  = 16383;
				v[CFG_DELAY_MEDIUM] = 16383;
				v[CFG_DELAY_LONG]   = 16383;
			end
			SET_NARROWEST: begin
				v[CFG_TICK_MS]      = 1;
				v[CFG_DUTY_FLOOR]   = 1000;
				v[CFG_DUTY_PEAK]    = 1000;
				v[CFG_STEP_LOW]     = 1;
				v[CFG_STEP_HIGH]    = 1;
				v[CFG_DELAY_SHORT]  = 0;
				v[CFG_DELAY_MEDIUM] = 0;
				v[CFG_DELAY_LONG]   = 0;
			end
			SET_ZERO_TICK: begin
				v[CFG_TICK_MS] = 0;
			end
			SET_MISORDERED: begin
				if ($urandom_range(0, 1) == 0) begin
					v[CFG_DUTY_FLOOR] = 1000000;
					v[CFG_DUTY_PEAK]  = 0;
				end else begin
					v[CFG_DUTY_FLOOR] = $urandom_range(30000, 60000);
					v[CFG_DUTY_PEAK]  = $urandom_range(0, 30000);
				end
			end
			SET_RAW: begin
				// Full-width data, so the block must drop the bits above each register.
				foreach (v[r])
					v[r] = $urandom_range(0, (1 << CFG_DATA_W) - 1);
			end
			default: ;
		endcase
		for (int r = 0; r < 8; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(r);
			cfg_data  <= v[r];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		in_item_t tick;
		int       zone;
		int       drain_at;
		int       p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(SET_DIRECTED);
		foreach (DIRECTED_TICKS[k])
			send_tick(DIRECTED_TICKS[k]);
		drain_results();

		zone = ZONE_LO;
		foreach (PHASE_PLAN[ph]) begin
			configure(PHASE_PLAN[ph]);
			drain_at = $urandom_range(10, TICKS_PER_PHASE - 10);
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if (n == drain_at)
					drain_results();
				// The pot dwells in one zone for a while so that sweeps run their course.
				if ($urandom_range(0, 29) == 0)
					zone = ZONE_PICK[$urandom_range(0, 9)];
				case (zone)
					ZONE_OFF: p = $urandom_range(0, 818);
					ZONE_INT: p = $urandom_range(1229, 1842);
					ZONE_LO:  p = $urandom_range(2253, 2866);
					ZONE_HI:  p = $urandom_range(3277, 4095);
					ZONE_DEAD: begin
						case ($urandom_range(0, 2))
							0:       p = $urandom_range(819, 1228);
							1:       p = $urandom_range(1843, 2252);
							default: p = $urandom_range(2867, 3276);
						endcase
					end
					default: p = $urandom_range(0, 4095);
				endcase
				if ($urandom_range(0, 7) == 0)
					p = $urandom_range(0, 4095);
				tick.ignition_on  = ($urandom_range(0, 15) != 0);
				tick.mode_pot     = p[11:0];
				tick.interval_pot = 12'($urandom_range(0, 4095));
				send_tick(tick);
			end
			drain_results();
		end

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/wsc_pkg.sv
rtl/wsc_front.sv
rtl/wsc_queue.sv
rtl/wsc_back.sv
rtl/wiper_sweep_controller.sv
rtl/wsc_checker.sv
verif/wiper_sweep_checker.sv
verif/tb_wiper_sweep_controller.sv
